// File: hw/rtl/i2cmb_pkg.sv
// i2cmb_pkg: shared types and constants for the I2C master bit engine.
// Used by every file under hw/rtl; depends on nothing.
`default_nettype none

package i2cmb_pkg;

  localparam int unsigned DelayW   = 16;
  localparam int unsigned PollW    = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DelayW-1:0] DelayReset = 16'd80;
  localparam logic [PollW-1:0]  PollReset  = 8'd50;

  // register map
  localparam logic [CfgIdxW-1:0] CfgDelayCycles  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAckPollLimit = 1'd1;

  // command codes
  localparam logic [ModeW-1:0] ModeStart = 3'd0;
  localparam logic [ModeW-1:0] ModeStop  = 3'd1;
  localparam logic [ModeW-1:0] ModeWrite = 3'd2;
  localparam logic [ModeW-1:0] ModeRead  = 3'd3;
  localparam logic [ModeW-1:0] ModeAck   = 3'd4;
  localparam logic [ModeW-1:0] ModeNak   = 3'd5;

  typedef struct packed {
    logic             cmd_valid;
    logic [ModeW-1:0] mode;
    logic [ByteW-1:0] write_byte;
    logic             sda_in;
  } in_item_t;

  typedef struct packed {
    logic             scl;
    logic             sda_out;
    logic             sda_drive;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_byte;
    logic             ack_seen;
  } out_item_t;

  typedef struct packed {
    logic [DelayW-1:0] delay_cycles;
    logic [PollW-1:0]  ack_poll_limit;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/i2c_master_bit_engine.sv
// Bit-level I2C master, one input beat per bus tick. Each input beat is one
// tick of the bus timebase and may carry a command (start, stop, write byte,
// read byte, master ack, master nak) plus the sampled SDA level; each input
// beat yields exactly one output beat with the SCL level, the SDA level and
// output enable, busy, a one-tick done pulse, the last read byte and the
// last write's ack status. Commands offered while busy, and modes 6 and 7,
// are ignored. Pin changes are spaced by delay_cycles ticks (0 acts as 1);
// the write ack is polled for up to ack_poll_limit delay units.
// Throughput is one beat per clock unless out_ready holds the output: a
// beat waits in the input register, the sequencer step is combinational
// logic, and the result lands in the engine's state registers, which drive
// out_item. in_ready drops only while a result is held by out_ready low.
// Configuration is to be written through the cfg_we/cfg_index/cfg_data
// port only while no beat is in flight; the block does not enforce this.
// Depends on i2cmb_pkg, i2cmb_cfg and i2cmb_engine.
`default_nettype none

module i2c_master_bit_engine (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire i2cmb_pkg::in_item_t            in_item,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output i2cmb_pkg::out_item_t                out_item,
  input  wire logic                           cfg_we,
  input  wire logic [i2cmb_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [i2cmb_pkg::CfgDataW-1:0] cfg_data
);
  import i2cmb_pkg::*;

  cfg_t     cfg;
  in_item_t s1_item;
  logic     s1_valid;
  logic     advance;

  // stage 1 moves into the engine when the output slot is free or leaving
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // output beat valid; payload comes straight from the engine registers,
  // which only move on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  i2cmb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cmb_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .cfg  (cfg),
    .res  (out_item)
  );

endmodule

`default_nettype wire

// File: hw/rtl/i2cmb_cfg.sv
// i2cmb_cfg: configuration register file (delay unit length, ack poll limit).
// Depends on i2cmb_pkg.
`default_nettype none

module i2cmb_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [i2cmb_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [i2cmb_pkg::CfgDataW-1:0]     cfg_data,
  output i2cmb_pkg::cfg_t                         cfg
);
  import i2cmb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_cycles   <= DelayReset;
      cfg.ack_poll_limit <= PollReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgDelayCycles:  cfg.delay_cycles   <= cfg_data[DelayW-1:0];
        CfgAckPollLimit: cfg.ack_poll_limit <= cfg_data[PollW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/i2cmb_engine.sv
// i2cmb_engine: bit-level sequencer; one tick per step, registers hold the
// bus lines and the result of the last tick. Depends on i2cmb_pkg.
`default_nettype none

module i2cmb_engine (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire i2cmb_pkg::in_item_t item,
  input  wire i2cmb_pkg::cfg_t     cfg,
  output i2cmb_pkg::out_item_t     res
);
  import i2cmb_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_A, PH_ST_B, PH_ST_C,
    PH_SP_A, PH_SP_B,
    PH_AK_A, PH_AK_B, PH_AK_C,
    PH_WB_A, PH_WB_B, PH_WB_C,
    PH_CK_A, PH_CK_B, PH_CK_P, PH_CK_C,
    PH_RD_A, PH_RD_B, PH_RD_C
  } phase_t;

  phase_t            phase, phase_next;
  logic [3:0]        bit_count, bit_count_next;
  logic [DelayW-1:0] delay_count, delay_count_next;
  logic [ByteW-1:0]  shift_byte, shift_byte_next;
  logic [PollW-1:0]  poll_count, poll_count_next;
  logic              scl, scl_next;
  logic              sda, sda_next;
  logic              drv, drv_next;
  logic              ack_flag, ack_flag_next;
  logic [ByteW-1:0]  held_read, held_read_next;
  logic              done, done_next;

  logic [DelayW-1:0] dly_load;
  logic [PollW-1:0]  poll_base;
  logic [3:0]        bit_inc;

  // zero delay acts as one tick
  assign dly_load  = (cfg.delay_cycles == '0) ? DelayW'(1) : cfg.delay_cycles;
  assign poll_base = (phase == PH_CK_B) ? '0 : poll_count;
  assign bit_inc   = bit_count + 4'd1;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    delay_count_next = delay_count;
    shift_byte_next  = shift_byte;
    poll_count_next  = poll_count;
    scl_next         = scl;
    sda_next         = sda;
    drv_next         = drv;
    ack_flag_next    = ack_flag;
    held_read_next   = held_read;
    done_next        = 1'b0;

    if (phase != PH_IDLE) begin
      if (delay_count > DelayW'(1)) begin
        delay_count_next = delay_count - DelayW'(1);
      end else begin
        delay_count_next = dly_load;
        unique case (phase) inside
          PH_ST_A: begin sda_next = 1'b0; phase_next = PH_ST_B; end
          PH_ST_B: begin scl_next = 1'b0; phase_next = PH_ST_C; end
          PH_SP_A: begin sda_next = 1'b1; phase_next = PH_SP_B; end
          PH_SP_B: begin
            drv_next         = 1'b0;
            phase_next       = PH_IDLE;
            delay_count_next = '0;
            done_next        = 1'b1;
          end
          PH_AK_A: begin scl_next = 1'b1; phase_next = PH_AK_B; end
          PH_AK_B: begin scl_next = 1'b0; phase_next = PH_AK_C; end
          PH_WB_A: begin scl_next = 1'b1; phase_next = PH_WB_B; end
          PH_WB_B: begin scl_next = 1'b0; phase_next = PH_WB_C; end
          PH_WB_C: begin
            bit_count_next = bit_inc;
            if (bit_inc < 4'd8) begin
              drv_next        = 1'b1;
              sda_next        = shift_byte[ByteW-1];
              shift_byte_next = {shift_byte[ByteW-2:0], 1'b0};
              phase_next      = PH_WB_A;
            end else begin
              drv_next   = 1'b0;
              sda_next   = 1'b1;
              phase_next = PH_CK_A;
            end
          end
          PH_CK_A: begin scl_next = 1'b1; phase_next = PH_CK_B; end
          PH_CK_B, PH_CK_P: begin
            // poll step: limit reached, ack low, or keep waiting
            if (poll_base >= cfg.ack_poll_limit) begin
              poll_count_next = poll_base;
              ack_flag_next   = 1'b0;
              scl_next        = 1'b0;
              phase_next      = PH_CK_C;
            end else if (!item.sda_in) begin
              poll_count_next = poll_base;
              ack_flag_next   = 1'b1;
              scl_next        = 1'b0;
              phase_next      = PH_CK_C;
            end else begin
              poll_count_next = poll_base + PollW'(1);
              phase_next      = PH_CK_P;
            end
          end
          PH_CK_C: begin
            drv_next         = 1'b1;
            phase_next       = PH_IDLE;
            delay_count_next = '0;
            done_next        = 1'b1;
          end
          PH_RD_A: begin scl_next = 1'b1; phase_next = PH_RD_B; end
          PH_RD_B: begin
            shift_byte_next = {shift_byte[ByteW-2:0], item.sda_in};
            scl_next        = 1'b0;
            phase_next      = PH_RD_C;
          end
          PH_RD_C: begin
            bit_count_next = bit_inc;
            if (bit_inc < 4'd8) begin
              drv_next   = 1'b0;
              phase_next = PH_RD_A;
            end else begin
              held_read_next   = shift_byte;
              phase_next       = PH_IDLE;
              delay_count_next = '0;
              done_next        = 1'b1;
            end
          end
          default: begin
            // start and ack end with SCL low and nothing more to do
            phase_next       = PH_IDLE;
            delay_count_next = '0;
            done_next        = 1'b1;
          end
        endcase
      end
    end else if (item.cmd_valid && item.mode <= ModeNak) begin
      bit_count_next   = '0;
      poll_count_next  = '0;
      delay_count_next = dly_load;
      unique case (item.mode) inside
        ModeStart: begin
          drv_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
          phase_next = PH_ST_A;
        end
        ModeStop: begin
          drv_next = 1'b1; sda_next = 1'b0; scl_next = 1'b1;
          phase_next = PH_SP_A;
        end
        ModeWrite: begin
          ack_flag_next   = 1'b0;
          drv_next        = 1'b1;
          sda_next        = item.write_byte[ByteW-1];
          shift_byte_next = {item.write_byte[ByteW-2:0], 1'b0};
          phase_next      = PH_WB_A;
        end
        ModeRead: begin
          shift_byte_next = '0;
          drv_next        = 1'b0;
          phase_next      = PH_RD_A;
        end
        ModeAck, ModeNak: begin
          sda_next   = (item.mode == ModeNak);
          drv_next   = 1'b1;
          phase_next = PH_AK_A;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      delay_count <= '0;
      shift_byte  <= '0;
      poll_count  <= '0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      drv         <= 1'b0;
      ack_flag    <= 1'b0;
      held_read   <= '0;
      done        <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      delay_count <= delay_count_next;
      shift_byte  <= shift_byte_next;
      poll_count  <= poll_count_next;
      scl         <= scl_next;
      sda         <= sda_next;
      drv         <= drv_next;
      ack_flag    <= ack_flag_next;
      held_read   <= held_read_next;
      done        <= done_next;
    end
  end

  assign res.scl       = scl;
  assign res.sda_out   = sda;
  assign res.sda_drive = drv;
  assign res.busy_res  = (phase != PH_IDLE);
  assign res.done_res  = done;
  assign res.read_byte = held_read;
  assign res.ack_seen  = ack_flag;

endmodule

`default_nettype wire

// File: hw/rtl/i2cmb_checker.sv
// i2cmb_checker: port-level assertions for i2c_master_bit_engine, bound in.
// Depends on i2cmb_pkg.
`default_nettype none

module i2cmb_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire i2cmb_pkg::out_item_t           out_item
);

  // a held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output beat changed while stalled");

  // input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // a finishing tick is never also busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.done_res && out_item.busy_res))
    else $error("done and busy together");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind i2c_master_bit_engine i2cmb_checker u_i2cmb_checker (.*);

`default_nettype wire
